[hdl/asc85_pkg.sv]
`timescale 1ns / 1ps

package asc85_pkg;

    // Character codes and group geometry of the Ascii85 alphabet.
    localparam logic [7:0] FirstDigit  = 8'd33;   // '!'
    localparam logic [7:0] LastDigit   = 8'd117;  // 'u'
    localparam logic [7:0] ZeroRunChar = 8'd122;  // 'z'
    localparam logic [7:0] SpaceChar   = 8'd32;
    localparam logic [7:0] CrChar      = 8'd13;
    localparam logic [7:0] LfChar      = 8'd10;
    localparam logic [31:0] DigitBase  = 32'd85;
    localparam int unsigned GroupBytes = 4;

    // One input request: a text character or the end marker.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_item_t;

    // One output request: a decoded byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
    } byte_item_t;

    // Accumulator state of the current group.
    typedef struct packed {
        logic [31:0] group_value;
        logic [2:0]  digit_count;
    } group_state_t;

    // Bytes produced by one input request, taken from the top of the word.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  byte_count;
    } step_result_t;

    // Scale that appends the missing digits of a group: 85 ** (5 - held).
    function automatic logic [31:0] fill_scale(input logic [2:0] held);
        logic [31:0] scale;
        unique case (held)
            // 85 ** 5 does not fit in 32 bits; this is its value modulo 2^32.
            3'd0:    scale = 32'd142085829;
            3'd1:    scale = 32'd52200625;
            3'd2:    scale = 32'd614125;
            3'd3:    scale = 32'd7225;
            3'd4:    scale = 32'd85;
            default: scale = 32'd1;
        endcase
        return scale;
    endfunction

endpackage

[hdl/ascii85_stream_decoder.sv]
`timescale 1ns / 1ps

// Channel  Payload      Handshake               Direction
// char     char_item_t  char_valid, char_stall  text characters and end marker in
// byte     byte_item_t  byte_valid, byte_stall  decoded bytes out, MSB of group first
//
// A character enters an input register and is decoded into a result register once the
// serializer is free or finishing; whitespace and digits that do not complete a group
// release no bytes. A request that releases n bytes holds the byte serializer until all
// n are taken (four for a full group), and the input register holds the next character meanwhile.
// Reset clears the group accumulator, the input register and the serializer.
// byte_stall freezes the current byte; char_stall rises only while both stages are full.

module ascii85_stream_decoder
    import asc85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_item_t char_data,
    output logic       byte_valid,
    input  logic       byte_stall,
    output byte_item_t byte_data
);

    logic         in_full_reg;
    logic         in_full_next;
    char_item_t   in_item_reg;
    group_state_t state_reg;
    group_state_t state_next;
    step_result_t step_result;
    logic [31:0]  res_word_reg;
    logic [2:0]   res_left_reg;
    logic [2:0]   res_left_next;
    logic [1:0]   res_pos_reg;
    logic [1:0]   res_pos_next;
    logic         char_take;
    logic         byte_take;
    logic         advance;

    // Decode of the held request against the group state.
    asc85_group_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Handshake: the held request moves on once the serializer is free or finishing.
    assign byte_valid = (res_left_reg != 3'd0);
    assign byte_take  = byte_valid && !byte_stall;
    assign advance    = in_full_reg
                     && ((res_left_reg == 3'd0) || ((res_left_reg == 3'd1) && byte_take));
    assign char_stall = in_full_reg && !advance;
    assign char_take  = char_valid && !char_stall;

    // Output byte selection, big-endian within the group.
    always_comb
    begin
        case (res_pos_reg)
            2'd0:    byte_data.data_byte = res_word_reg[31:24];
            2'd1:    byte_data.data_byte = res_word_reg[23:16];
            2'd2:    byte_data.data_byte = res_word_reg[15:8];
            default: byte_data.data_byte = res_word_reg[7:0];
        endcase
        byte_data.last_of_run = (res_left_reg == 3'd1);
    end

    // Next values of the input stage and the serializer.
    always_comb
    begin
        in_full_next  = in_full_reg;
        res_left_next = res_left_reg;
        res_pos_next  = res_pos_reg;
        if (char_take)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
        if (advance)
        begin
            res_left_next = step_result.byte_count;
            res_pos_next  = 2'd0;
        end
        else if (byte_take)
        begin
            res_left_next = res_left_reg - 3'd1;
            res_pos_next  = res_pos_reg + 2'd1;
        end
    end

    // Control state and group accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            res_left_reg <= 3'd0;
            res_pos_reg  <= 2'd0;
            state_reg    <= '0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            res_left_reg <= res_left_next;
            res_pos_reg  <= res_pos_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (char_take)
        begin
            in_item_reg <= char_data;
        end
        if (advance)
        begin
            res_word_reg <= step_result.word;
        end
    end

    // The digit count never leaves the range of a partial group.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digit_count <= 3'd4)
        else $error("digit count out of range");

    // An empty group always has a zero accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.digit_count == 3'd0) |-> (state_reg.group_value == 32'd0))
        else $error("accumulator not cleared with empty group");

    // A held request that cannot move on stays in the input register unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !advance) |=> (in_full_reg && $stable(in_item_reg)))
        else $error("held request lost or changed");

    // After a byte is taken with more to come, the next byte follows in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_take && (res_left_reg > 3'd1))
        |=> (byte_valid && (res_pos_reg == ($past(res_pos_reg) + 2'd1))))
        else $error("byte sequence broken");

endmodule

[hdl/asc85_group_step.sv]
`timescale 1ns / 1ps

module asc85_group_step
    import asc85_pkg::*;
(
    input  group_state_t state,
    input  char_item_t   item,
    output group_state_t state_next,
    output step_result_t result
);

    logic        is_space;
    logic        is_zero_run;
    logic        is_digit;
    logic        use_fill;
    logic [31:0] digit_value;
    logic [31:0] scale;
    logic [31:0] addend;
    logic [31:0] product;
    logic [31:0] sum;

    // Classify the character.
    assign is_space    = (item.char_code == SpaceChar) || (item.char_code == CrChar)
                      || (item.char_code == LfChar);
    assign is_zero_run = (item.char_code == ZeroRunChar);
    assign is_digit    = (item.char_code >= FirstDigit) && (item.char_code <= LastDigit);
    assign digit_value = is_digit ? {24'd0, item.char_code - FirstDigit} : 32'd0;

    // The end marker and 'z' both append the missing digits of the group at once.
    assign use_fill = item.end_of_text || is_zero_run;
    assign scale    = use_fill ? fill_scale(state.digit_count) : DigitBase;

    // Padding with 'u' digits adds 85**n - 1 to the scaled value.
    always_comb
    begin
        if (item.end_of_text)
        begin
            addend = scale - 32'd1;
        end
        else if (is_zero_run)
        begin
            addend = 32'd0;
        end
        else
        begin
            addend = digit_value;
        end
    end

    // One multiply and one add, both modulo 2^32.
    assign product = 32'(state.group_value * scale);
    assign sum     = product + addend;

    // Next group state and the bytes this request releases.
    always_comb
    begin
        state_next        = state;
        result.word       = sum;
        result.byte_count = 3'd0;
        if (item.end_of_text)
        begin
            state_next = '0;
            if (state.digit_count >= 3'd2)
            begin
                result.byte_count = state.digit_count - 3'd1;
            end
        end
        else if (is_space)
        begin
            state_next = state;
        end
        else if (is_zero_run)
        begin
            // The group completes and the same number of zero digits stays held.
            state_next.group_value = 32'd0;
            result.byte_count      = 3'(GroupBytes);
        end
        else if (state.digit_count >= 3'd4)
        begin
            state_next        = '0;
            result.byte_count = 3'(GroupBytes);
        end
        else
        begin
            state_next.group_value = sum;
            state_next.digit_count = state.digit_count + 3'd1;
        end
    end

endmodule

[dv/tb_ascii85_stream_decoder.sv]
`timescale 1ns / 1ps

module tb_ascii85_stream_decoder;

    import asc85_pkg::*;

    localparam int unsigned GroupDigits   = 5;
    localparam logic [31:0] PadDigit      = 32'd84;
    localparam int unsigned StallLimit    = 2000;
    localparam int unsigned SettleCycles  = 16;
    localparam int unsigned PhaseRequests = 115;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       char_valid = 1'b0;
    logic       char_stall;
    char_item_t char_data = '0;
    logic       byte_valid;
    logic       byte_stall = 1'b0;
    byte_item_t byte_data;

    // Decoder state as the testbench expects it.
    logic [31:0] acc_value = '0;
    logic [2:0]  acc_digits = '0;
    byte_item_t  expected_bytes[$];

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned requests_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    ascii85_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Queue the top n bytes of a group word, most significant first.
    function automatic void queue_group_bytes(input logic [31:0] word, input int unsigned n);
        byte_item_t b;
        for (int unsigned i = 0; i < n; i++)
        begin
            b.data_byte   = word[31 - 8 * i -: 8];
            b.last_of_run = (i + 1 == n);
            expected_bytes.insert(expected_bytes.size(), b);
        end
    endfunction

    // Append one base-85 digit; a fifth digit releases the whole group.
    function automatic void add_base85_digit(input logic [7:0] digit);
        acc_value  = acc_value * DigitBase + {24'd0, digit};
        acc_digits = acc_digits + 3'd1;
        if (acc_digits >= GroupDigits)
        begin
            queue_group_bytes(acc_value, GroupBytes);
            acc_value  = '0;
            acc_digits = '0;
        end
    endfunction

    // Work out the bytes that one accepted request releases.
    function automatic void predict_decoded_bytes(input char_item_t item);
        logic [31:0] padded;
        if (item.end_of_text)
        begin
            // A partial group of k digits is padded with 'u' and gives k-1 bytes.
            if (acc_digits >= 3'd2)
            begin
                padded = acc_value;
                for (int unsigned i = int'(acc_digits); i < GroupDigits; i++)
                    padded = padded * DigitBase + PadDigit;
                queue_group_bytes(padded, int'(acc_digits) - 1);
            end
            acc_value  = '0;
            acc_digits = '0;
        end
        else if (item.char_code == SpaceChar || item.char_code == CrChar ||
                 item.char_code == LfChar)
        begin
            // Whitespace is skipped.
        end
        else if (item.char_code == ZeroRunChar)
        begin
            for (int unsigned i = 0; i < GroupDigits; i++)
                add_base85_digit(8'd0);
        end
        else if (item.char_code >= FirstDigit && item.char_code <= LastDigit)
            add_base85_digit(item.char_code - FirstDigit);
        else
            add_base85_digit(8'd0);
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_request(input logic [7:0] code, input logic eot);
        char_item_t item;
        item.char_code   = code;
        item.end_of_text = eot;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= item;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        predict_decoded_bytes(item);
        requests_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_request(text[i], 1'b0);
    endtask

    // Complete groups: the all-ones word and a group that wraps past 2^32.
    task automatic test_full_groups();
        send_text("s8W-!");
        send_text("uuuuu");
    endtask

    // 'z' on a group boundary and inside a group, whitespace and foreign characters.
    task automatic test_zero_runs_and_skips();
        send_text("z");
        send_request(8'h00, 1'b0);
        send_text(" \r\n");
        send_request(8'hFF, 1'b0);
        send_text("z");
        send_request(8'hFF, 1'b1);
    endtask

    // End markers with nothing held, one digit held and four digits held.
    task automatic test_end_markers();
        send_request(8'h00, 1'b1);
        send_text("v");
        send_request(8'h5A, 1'b1);
        send_text("~{y!");
        send_request(8'hA5, 1'b1);
    endtask

    // Mostly well-formed text with random content, plus end markers and noise.
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned count);
        int unsigned pick;
        logic [7:0]  code;
        logic        eot;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            eot  = 1'b0;
            code = 8'($urandom_range(FirstDigit, LastDigit));
            if (pick < 8)
            begin
                case ($urandom_range(0, 2))
                    0:       code = SpaceChar;
                    1:       code = CrChar;
                    default: code = LfChar;
                endcase
            end
            else if (pick < 14)
                code = ZeroRunChar;
            else if (pick < 20)
            begin
                eot  = 1'b1;
                code = 8'($urandom_range(0, 255));
            end
            else if (pick < 28)
                code = 8'($urandom_range(0, 255));
            send_request(code, eot);
        end
    endtask

    // Receiver: random stalls and an in-order check of every accepted byte.
    always @(posedge clk)
    begin
        byte_item_t want;
        byte_stall <= rst_n && ($urandom_range(0, 99) < receiver_stall_pct);
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got data %02h last %0b",
                         $time, byte_data.data_byte, byte_data.last_of_run);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (byte_data.data_byte !== want.data_byte ||
                    byte_data.last_of_run !== want.last_of_run)
                begin
                    $display({"%0t: byte mismatch: expected data %02h last %0b, ",
                              "got data %02h last %0b"},
                             $time, want.data_byte, want.last_of_run,
                             byte_data.data_byte, byte_data.last_of_run);
                    error_count++;
                end
                bytes_checked++;
            end
        end
    end

    // Watchdog: too many cycles in a row without any accepted request ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (byte_valid && !byte_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
                $display("FAIL ascii85_stream_decoder");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_groups();
        test_zero_runs_and_skips();
        test_end_markers();
        test_random_traffic(0, 0, PhaseRequests);
        test_random_traffic(73, 0, PhaseRequests);
        test_random_traffic(0, 73, PhaseRequests);
        test_random_traffic(8, 8, PhaseRequests);
        char_valid <= 1'b0;

        // Let the last bytes come out, then watch for anything extra.
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        $display("Sent %0d requests (directed groups, zero runs, end markers, random text)",
                 requests_sent);
        $display("Checked %0d bytes across four idle and stall phases", bytes_checked);
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("PASS ascii85_stream_decoder");
        else
            $display("FAIL ascii85_stream_decoder");
        $finish;
    end

endmodule

[sim.f]
hdl/asc85_pkg.sv
hdl/asc85_group_step.sv
hdl/ascii85_stream_decoder.sv
dv/tb_ascii85_stream_decoder.sv
